// ----- rtl/galc_pkg.sv -----
package galc_pkg;

    // Field widths
    localparam int LEVEL_W    = 12;
    localparam int TEMP_W     = 12;
    localparam int TIME_W     = 32;
    localparam int STATE_W    = 4;
    localparam int FLAGS_W    = 3;
    localparam int NUM_CH     = 3;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Enable mask bit for the temperature sensor (gas channels use bits 0..2)
    localparam int TEMP_EN_BIT = 3;

    // Rate-of-rise compare: delta * RATE_SCALE >= limit * elapsed
    localparam int RATE_SCALE = 1000;
    localparam int LIMIT_W    = 12;
    localparam int RATE_W     = LIMIT_W + TIME_W + 2;

    // Default tuning values
    localparam int DEF_HYSTERESIS       = 100;
    localparam int DEF_SAFE_BAND        = 100;
    localparam int DEF_RATE_LIMIT       = 50;
    localparam int DEF_RATE_INTERVAL_MS = 1000;
    localparam int DEF_EXTREME_TEMP     = 500;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_WARN_LEVEL   = 12'd1500;
    localparam logic [LEVEL_W-1:0] RST_DANGER_LEVEL = 12'd2500;
    localparam logic [MASK_W-1:0]  RST_ENABLE_MASK  = 4'hF;
    localparam logic [TEMP_W-1:0]  RST_TEMP_WARN    = 12'd400;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAS_A_WARN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_A_DANGER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_B_WARN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_B_DANGER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_C_WARN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_C_DANGER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN    = 3'd7;

    // System state codes
    localparam logic [STATE_W-1:0] ST_BOOT     = 4'd0;
    localparam logic [STATE_W-1:0] ST_HEATING  = 4'd1;
    localparam logic [STATE_W-1:0] ST_FAULT    = 4'd2;
    localparam logic [STATE_W-1:0] ST_SAFE     = 4'd3;
    localparam logic [STATE_W-1:0] ST_NORMAL   = 4'd4;
    localparam logic [STATE_W-1:0] ST_MODERATE = 4'd5;
    localparam logic [STATE_W-1:0] ST_WARNING  = 4'd6;
    localparam logic [STATE_W-1:0] ST_DANGER   = 4'd7;
    localparam logic [STATE_W-1:0] ST_CRITICAL = 4'd8;

    // One captured sample set
    typedef struct packed {
        logic [LEVEL_W-1:0] gas_a_level;
        logic [LEVEL_W-1:0] gas_b_level;
        logic [LEVEL_W-1:0] gas_c_level;
        logic [TEMP_W-1:0]  temperature;
        logic               temp_valid;
        logic               heating;
        logic               fault;
        logic [TIME_W-1:0]  now_ms;
    } sample_t;

    // Per-channel evaluation results
    typedef struct packed {
        logic warn;
        logic danger;
        logic safe;
        logic rise;
    } chan_status_t;

endpackage

// ----- rtl/galc_ifs.sv -----
interface galc_sample_if;
    logic                         valid;
    logic                         ready;
    logic [galc_pkg::LEVEL_W-1:0] gas_a_level;
    logic [galc_pkg::LEVEL_W-1:0] gas_b_level;
    logic [galc_pkg::LEVEL_W-1:0] gas_c_level;
    logic signed [galc_pkg::TEMP_W-1:0] temperature;
    logic                         temp_valid;
    logic                         heating;
    logic                         fault;
    logic [galc_pkg::TIME_W-1:0]  now_ms;

    modport source (
        output valid, gas_a_level, gas_b_level, gas_c_level, temperature,
               temp_valid, heating, fault, now_ms,
        input  ready
    );
    modport sink (
        input  valid, gas_a_level, gas_b_level, gas_c_level, temperature,
               temp_valid, heating, fault, now_ms,
        output ready
    );
endinterface

interface galc_result_if;
    logic                         valid;
    logic                         ready;
    logic [galc_pkg::STATE_W-1:0] system_state;
    logic [galc_pkg::STATE_W-1:0] previous_state;
    logic [galc_pkg::FLAGS_W-1:0] warning_flags;
    logic [galc_pkg::FLAGS_W-1:0] danger_flags;
    logic                         rate_alert;

    modport source (
        output valid, system_state, previous_state, warning_flags, danger_flags,
               rate_alert,
        input  ready
    );
    modport sink (
        input  valid, system_state, previous_state, warning_flags, danger_flags,
               rate_alert,
        output ready
    );
endinterface

interface galc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [galc_pkg::CFG_IDX_W-1:0]  index;
    logic [galc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/galc_chan.sv -----
module galc_chan #(
    parameter int HYSTERESIS = galc_pkg::DEF_HYSTERESIS,
    parameter int SAFE_BAND  = galc_pkg::DEF_SAFE_BAND,
    parameter int RATE_LIMIT = galc_pkg::DEF_RATE_LIMIT
) (
    input  logic [galc_pkg::LEVEL_W-1:0] level,
    input  logic [galc_pkg::LEVEL_W-1:0] last_level,
    input  logic [galc_pkg::LEVEL_W-1:0] warn_thr,
    input  logic [galc_pkg::LEVEL_W-1:0] danger_thr,
    input  logic                         warn_held,
    input  logic                         danger_held,
    input  logic [galc_pkg::TIME_W-1:0]  elapsed,
    output galc_pkg::chan_status_t       status
);
    import galc_pkg::*;

    localparam int CMP_W = LEVEL_W + 2;
    localparam logic signed [CMP_W-1:0] HYST_S   = CMP_W'(HYSTERESIS);
    localparam logic signed [CMP_W-1:0] MARGIN_S = CMP_W'(SAFE_BAND);
    localparam logic [LIMIT_W-1:0]      LIMIT_U  = LIMIT_W'(RATE_LIMIT);
    localparam logic signed [RATE_W-1:0] SCALE_S = RATE_W'(RATE_SCALE);

    logic signed [CMP_W-1:0]      level_s;
    logic signed [CMP_W-1:0]      warn_bound;
    logic signed [CMP_W-1:0]      danger_bound;
    logic signed [CMP_W-1:0]      safe_bound;
    logic signed [LEVEL_W:0]      delta;
    logic signed [RATE_W-1:0]     lhs;
    logic [LIMIT_W+TIME_W-1:0]    rhs_u;
    logic signed [RATE_W-1:0]     rhs;

    // A held latch releases only below threshold - hysteresis; may go negative
    assign level_s      = $signed({2'b00, level});
    assign warn_bound   = $signed({2'b00, warn_thr}) - (warn_held ? HYST_S : '0);
    assign danger_bound = $signed({2'b00, danger_thr}) - (danger_held ? HYST_S : '0);
    assign safe_bound   = $signed({2'b00, warn_thr}) - MARGIN_S;

    // Rise test without division: delta * scale >= limit * elapsed
    assign delta = $signed({1'b0, level}) - $signed({1'b0, last_level});
    assign lhs   = RATE_W'(delta) * SCALE_S;
    assign rhs_u = (LIMIT_W + TIME_W)'(LIMIT_U) * (LIMIT_W + TIME_W)'(elapsed);
    assign rhs   = $signed({2'b00, rhs_u});

    assign status.warn   = level_s >= warn_bound;
    assign status.danger = level_s >= danger_bound;
    assign status.safe   = level_s < safe_bound;
    assign status.rise   = lhs >= rhs;

endmodule

// ----- rtl/gas_alarm_level_classifier.sv -----
// Gas alarm level classifier. Each beat on the sample channel carries three
// gas readings, a temperature in signed tenths of a degree, heating/fault
// flags and a millisecond timestamp; each one produces exactly one beat on
// the result channel with the new and previous system state, the per-channel
// warning/danger latches and the rate-of-rise alert. Fault wins over heating,
// and both leave the latches and the rise bookkeeping untouched. Thresholds,
// the channel enable mask and the temperature warning level are written on
// the cfg channel (always ready); the user must write them only while no
// sample is in flight, as the block itself does not enforce this. Throughput
// is one sample per clock while result.ready stays high; one input register,
// then the whole evaluation, combinational, into the result register, which
// is also where the latch state updates.
// A stalled result holds the input register, so sample.ready follows
// result.ready combinationally when both stages are full.
module gas_alarm_level_classifier #(
    parameter int HYSTERESIS       = galc_pkg::DEF_HYSTERESIS,
    parameter int SAFE_BAND        = galc_pkg::DEF_SAFE_BAND,
    parameter int RATE_LIMIT       = galc_pkg::DEF_RATE_LIMIT,
    parameter int RATE_INTERVAL_MS = galc_pkg::DEF_RATE_INTERVAL_MS,
    parameter int EXTREME_TEMP     = galc_pkg::DEF_EXTREME_TEMP
) (
    input  logic          clk,
    input  logic          rst_n,
    galc_sample_if.sink   sample,
    galc_cfg_if.sink      cfg,
    galc_result_if.source result
);
    import galc_pkg::*;

    localparam logic [TIME_W-1:0]        INTERVAL  = TIME_W'(RATE_INTERVAL_MS);
    localparam logic signed [TEMP_W:0]   EXTREME_S = (TEMP_W + 1)'(EXTREME_TEMP);

    // ---------------- configuration registers ----------------
    logic [LEVEL_W-1:0] warn_level_reg   [NUM_CH];
    logic [LEVEL_W-1:0] danger_level_reg [NUM_CH];
    logic [MASK_W-1:0]  enable_mask_reg;
    logic [TEMP_W-1:0]  temp_warn_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                warn_level_reg[i]   <= RST_WARN_LEVEL;
                danger_level_reg[i] <= RST_DANGER_LEVEL;
            end
            enable_mask_reg <= RST_ENABLE_MASK;
            temp_warn_reg   <= RST_TEMP_WARN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAS_A_WARN:   warn_level_reg[0]   <= cfg.data;
                REG_GAS_A_DANGER: danger_level_reg[0] <= cfg.data;
                REG_GAS_B_WARN:   warn_level_reg[1]   <= cfg.data;
                REG_GAS_B_DANGER: danger_level_reg[1] <= cfg.data;
                REG_GAS_C_WARN:   warn_level_reg[2]   <= cfg.data;
                REG_GAS_C_DANGER: danger_level_reg[2] <= cfg.data;
                REG_ENABLE_MASK:  enable_mask_reg     <= cfg.data[MASK_W-1:0];
                REG_TEMP_WARN:    temp_warn_reg       <= cfg.data;
                default:          ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic    in_valid_reg;
    sample_t in_reg;
    logic    res_valid_reg;
    logic    res_free;
    logic    fire;

    assign res_free     = !res_valid_reg || result.ready;
    assign fire         = in_valid_reg && res_free;
    assign sample.ready = !in_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (res_free)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input register: payload only
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_reg.gas_a_level <= sample.gas_a_level;
            in_reg.gas_b_level <= sample.gas_b_level;
            in_reg.gas_c_level <= sample.gas_c_level;
            in_reg.temperature <= sample.temperature;
            in_reg.temp_valid  <= sample.temp_valid;
            in_reg.heating     <= sample.heating;
            in_reg.fault       <= sample.fault;
            in_reg.now_ms      <= sample.now_ms;
        end
    end

    // ---------------- classifier state ----------------
    logic [STATE_W-1:0] state_reg;
    logic [FLAGS_W-1:0] warn_latch_reg;
    logic [FLAGS_W-1:0] danger_latch_reg;
    logic [LEVEL_W-1:0] last_level_reg [NUM_CH];
    logic [TIME_W-1:0]  last_rate_time_reg;
    logic               rate_alert_reg;

    logic [LEVEL_W-1:0] levels [NUM_CH];
    logic [TIME_W-1:0]  elapsed;
    logic               rate_due;
    logic               active;
    chan_status_t       chan_status [NUM_CH];

    logic [FLAGS_W-1:0] warn_latch_next;
    logic [FLAGS_W-1:0] danger_latch_next;
    logic               rate_alert_next;
    logic [STATE_W-1:0] state_next;

    logic [NUM_CH-1:0]  eval_warn;
    logic [NUM_CH-1:0]  eval_danger;
    logic [NUM_CH-1:0]  rise;
    logic               all_safe;
    logic               two_danger;
    logic               temp_on;
    logic signed [TEMP_W-1:0] temp_s;

    assign levels[0] = in_reg.gas_a_level;
    assign levels[1] = in_reg.gas_b_level;
    assign levels[2] = in_reg.gas_c_level;

    // Elapsed time wraps with the timestamp
    assign elapsed  = in_reg.now_ms - last_rate_time_reg;
    assign rate_due = elapsed >= INTERVAL;
    assign active   = !in_reg.fault && !in_reg.heating;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_chan
        galc_chan #(
            .HYSTERESIS (HYSTERESIS),
            .SAFE_BAND  (SAFE_BAND),
            .RATE_LIMIT (RATE_LIMIT)
        ) u_chan (
            .level       (levels[ch]),
            .last_level  (last_level_reg[ch]),
            .warn_thr    (warn_level_reg[ch]),
            .danger_thr  (danger_level_reg[ch]),
            .warn_held   (warn_latch_reg[ch]),
            .danger_held (danger_latch_reg[ch]),
            .elapsed     (elapsed),
            .status      (chan_status[ch])
        );

        // Disabled channels clear their latches but still feed the rise check
        assign eval_warn[ch]   = enable_mask_reg[ch] && chan_status[ch].warn;
        assign eval_danger[ch] = enable_mask_reg[ch] && chan_status[ch].danger;
        assign rise[ch]        = chan_status[ch].rise;
    end

    always_comb
    begin
        all_safe = 1'b1;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (enable_mask_reg[i] && !chan_status[i].safe)
            begin
                all_safe = 1'b0;
            end
        end
    end

    assign two_danger = (eval_danger[0] && eval_danger[1]) ||
                        (eval_danger[0] && eval_danger[2]) ||
                        (eval_danger[1] && eval_danger[2]);
    assign temp_on    = enable_mask_reg[TEMP_EN_BIT] && in_reg.temp_valid;
    assign temp_s     = $signed(in_reg.temperature);

    assign warn_latch_next   = active ? eval_warn : warn_latch_reg;
    assign danger_latch_next = active ? eval_danger : danger_latch_reg;
    assign rate_alert_next   = (active && rate_due) ? (|rise) : rate_alert_reg;

    // Priority: fault, heating, then critical down to normal
    always_comb
    begin
        if (in_reg.fault)
        begin
            state_next = ST_FAULT;
        end
        else if (in_reg.heating)
        begin
            state_next = ST_HEATING;
        end
        else if (two_danger ||
                 (temp_on && ($signed({temp_s[TEMP_W-1], temp_s}) >= EXTREME_S)))
        begin
            state_next = ST_CRITICAL;
        end
        else if (|eval_danger)
        begin
            state_next = ST_DANGER;
        end
        else if ((|eval_warn) || (temp_on && (temp_s >= $signed(temp_warn_reg))))
        begin
            state_next = ST_WARNING;
        end
        else if (rate_alert_next)
        begin
            state_next = ST_MODERATE;
        end
        else if (all_safe)
        begin
            state_next = ST_SAFE;
        end
        else
        begin
            state_next = ST_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_BOOT;
            warn_latch_reg     <= '0;
            danger_latch_reg   <= '0;
            last_rate_time_reg <= '0;
            rate_alert_reg     <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_level_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            state_reg        <= state_next;
            warn_latch_reg   <= warn_latch_next;
            danger_latch_reg <= danger_latch_next;
            rate_alert_reg   <= rate_alert_next;
            if (active && rate_due)
            begin
                last_rate_time_reg <= in_reg.now_ms;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    last_level_reg[i] <= levels[i];
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic [STATE_W-1:0] res_state_reg;
    logic [STATE_W-1:0] res_prev_reg;
    logic [FLAGS_W-1:0] res_warn_reg;
    logic [FLAGS_W-1:0] res_danger_reg;
    logic               res_alert_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_state_reg  <= state_next;
            res_prev_reg   <= state_reg;
            res_warn_reg   <= warn_latch_next;
            res_danger_reg <= danger_latch_next;
            res_alert_reg  <= rate_alert_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.system_state   = res_state_reg;
    assign result.previous_state = res_prev_reg;
    assign result.warning_flags  = res_warn_reg;
    assign result.danger_flags   = res_danger_reg;
    assign result.rate_alert     = res_alert_reg;

endmodule
